// File: hdl/iirc_pkg.sv
// ----------------------------------------------------------------------------
// iirc_pkg - shared types and constants of the interlock relay controller
// Event codes, relay modes, register indexes, field widths and the status
// word of the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iirc_pkg;

   localparam int DLY_W   = 12;   // second countdowns and delay registers
   localparam int MIN_W   = 16;   // drive minutes and reminder marks
   localparam int REP_W   = 8;    // repeat reminder interval
   localparam int DEB_W   = 3;    // debounce threshold
   localparam int LVL_W   = 4;    // signed debounce level
   localparam int MODE_W  = 3;
   localparam int SEC_W   = 6;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 16;

   // event codes
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_SECOND = 2'd1;
   localparam logic [1:0] ACT_MINUTE = 2'd2;
   localparam logic [1:0] ACT_BREATH = 2'd3;

   // relay modes
   localparam logic [MODE_W-1:0] MODE_TRIPPED = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DRIVING = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OFF_CNT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ARM_CNT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ALCOHOL = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAN   = 3'd5;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ARM_DELAY  = 3'd0;
   localparam logic [IDX_W-1:0] REG_OFF_DELAY  = 3'd1;
   localparam logic [IDX_W-1:0] REG_CLEAN_WIN  = 3'd2;
   localparam logic [IDX_W-1:0] REG_REC_HOLD   = 3'd3;
   localparam logic [IDX_W-1:0] REG_FIRST_REM  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SECOND_REM = 3'd5;
   localparam logic [IDX_W-1:0] REG_REPEAT_REM = 3'd6;
   localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd7;

   // reset values
   localparam logic [DLY_W-1:0] ARM_DELAY_RST  = 12'd900;
   localparam logic [DLY_W-1:0] OFF_DELAY_RST  = 12'd1200;
   localparam logic [DLY_W-1:0] CLEAN_WIN_RST  = 12'd300;
   localparam logic [DLY_W-1:0] REC_HOLD_RST   = 12'd360;
   localparam logic [MIN_W-1:0] FIRST_REM_RST  = 16'd120;
   localparam logic [MIN_W-1:0] SECOND_REM_RST = 16'd180;
   localparam logic [REP_W-1:0] REPEAT_REM_RST = 8'd30;
   localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 3'd3;

   typedef struct packed {
      logic done;   // one-cycle pulse, remainder valid
      logic zero;   // remainder is zero
   } rem_status_type;

endpackage

`default_nettype wire

// File: hdl/ignition_interlock_relay_controller.sv
// ----------------------------------------------------------------------------
// ignition_interlock_relay_controller - breath-alcohol interlock relay control
// Debounces ignition, counts drive minutes, raises drive-time reminders,
// runs the relay mode machine and the recording hold.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is taken only when the block is idle
// and its result is loaded through the evaluate and commit states. A second
// tick that falls on a reminder slot past the second reminder mark, with a
// nonzero repeat interval, also runs the bit-serial remainder unit between
// evaluate and commit; the unit divides and then reports, and the result is
// loaded in commit after that report. A result that is not taken holds the
// block in commit. Input is not taken while a word is at work; a finished
// result sits in the output register while the next word is accepted.
// Configuration writes are always taken and are meant for idle periods. After
// reset the relay mode is driving with the relay open and all counts at zero.
`default_nettype none

module ignition_interlock_relay_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic                          req_ignition_level,
   input  wire logic                          req_alcohol_found,
   input  wire logic                          req_pairing_busy,
   input  wire logic [iirc_pkg::SEC_W-1:0]    req_seconds_now,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_relay_on,
   output      logic                          rsp_ignition_on,
   output      logic                          rsp_remind_pulse,
   output      logic                          rsp_recording_on,
   output      logic [iirc_pkg::MODE_W-1:0]   rsp_mode,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [iirc_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [iirc_pkg::DATA_W-1:0]   csr_wdata
);
   import iirc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // configuration
   logic [DLY_W-1:0] arm_delay_ff, off_delay_ff, clean_win_ff, rec_hold_ff;
   logic [MIN_W-1:0] first_rem_ff, second_rem_ff;
   logic [REP_W-1:0] repeat_rem_ff;
   logic [DEB_W-1:0] debounce_ff;

   // controller state
   logic [1:0]              state_ff, state_in;
   logic signed [LVL_W-1:0] level_ff, level_in;
   logic                    ign_ff, ign_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic                    closed_ff, closed_in;
   logic [DLY_W-1:0]        off_cnt_ff, off_cnt_in;
   logic [DLY_W-1:0]        arm_cnt_ff, arm_cnt_in;
   logic [MIN_W-1:0]        minutes_ff, minutes_in;
   logic [DLY_W-1:0]        rec_cnt_ff, rec_cnt_in;
   logic                    pulse_ff, pulse_in;

   // captured word
   logic [1:0]       act_ff;
   logic             lvl_ff, alc_ff, pair_ff;
   logic [SEC_W-1:0] secs_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_relay_ff, out_ign_ff, out_pulse_ff, out_rec_ff;
   logic [MODE_W-1:0] out_mode_ff;

   logic             accept;
   logic             commit;
   logic             slot;
   logic             mark_hit;
   logic             div_start;
   rem_status_type   rem_status;
   logic [DLY_W-1:0] rec_load;
   logic signed [LVL_W:0]   thr_pos, thr_neg, lvl_step;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // reminder slot: seconds mod 20 equal to 1 over the whole 6-bit range
   assign slot = (secs_ff == 6'd1) || (secs_ff == 6'd21) || (secs_ff == 6'd41) ||
                 (secs_ff == 6'd61);
   assign mark_hit = (minutes_ff == first_rem_ff) || (minutes_ff == second_rem_ff);
   assign div_start = (state_ff == ST_CALC) && (act_ff == ACT_SECOND) && slot &&
                      !mark_hit && (minutes_ff > second_rem_ff) &&
                      (repeat_rem_ff != '0);

   iirc_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (minutes_ff - second_rem_ff),
      .divisor  (repeat_rem_ff),
      .status   (rem_status)
   );

   // sequencer and reminder decision
   always_comb begin
      state_in = state_ff;
      pulse_in = pulse_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            pulse_in = (act_ff == ACT_SECOND) && slot && mark_hit;
            state_in = div_start ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (rem_status.done) begin
               pulse_in = rem_status.zero;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // event update, applied at commit
   always_comb begin
      level_in   = level_ff;
      ign_in     = ign_ff;
      mode_in    = mode_ff;
      closed_in  = closed_ff;
      off_cnt_in = off_cnt_ff;
      arm_cnt_in = arm_cnt_ff;
      minutes_in = minutes_ff;
      rec_cnt_in = rec_cnt_ff;
      rec_load   = rec_cnt_ff;
      thr_pos    = $signed({2'b00, debounce_ff});
      thr_neg    = -thr_pos;
      lvl_step   = {level_ff[LVL_W-1], level_ff};
      case (act_ff)
         ACT_SAMPLE: begin
            if (lvl_ff) begin
               if (level_ff != 4'sd7) begin
                  lvl_step = lvl_step + 5'sd1;
               end
               level_in = lvl_step[LVL_W-1:0];
               if (lvl_step >= thr_pos) begin
                  ign_in   = 1'b1;
                  level_in = 4'sd4;
               end
            end else begin
               if (level_ff != -4'sd8) begin
                  lvl_step = lvl_step - 5'sd1;
               end
               level_in = lvl_step[LVL_W-1:0];
               if (lvl_step < thr_neg) begin
                  ign_in   = 1'b0;
                  level_in = -4'sd4;
               end
            end
         end
         ACT_SECOND: begin
            if (!pair_ff) begin
               case (mode_ff)
                  MODE_TRIPPED: begin
                     if (!ign_ff) begin
                        closed_in  = 1'b0;
                        off_cnt_in = '0;
                     end else begin
                        mode_in    = MODE_ARM_CNT;
                        arm_cnt_in = arm_delay_ff;
                     end
                  end
                  MODE_DRIVING: begin
                     if (ign_ff) begin
                        closed_in  = 1'b1;
                        arm_cnt_in = '0;
                     end else begin
                        off_cnt_in = off_delay_ff;
                        mode_in    = MODE_OFF_CNT;
                     end
                  end
                  MODE_OFF_CNT: begin
                     if (ign_ff) begin
                        mode_in = MODE_DRIVING;
                     end else if (off_cnt_ff != '0) begin
                        off_cnt_in = off_cnt_ff - 1'b1;
                        if (off_cnt_ff == DLY_W'(1)) begin
                           mode_in = MODE_TRIPPED;
                        end
                     end
                  end
                  MODE_ARM_CNT: begin
                     if (!ign_ff) begin
                        mode_in = MODE_TRIPPED;
                     end else if (arm_cnt_ff != '0) begin
                        arm_cnt_in = arm_cnt_ff - 1'b1;
                        if (arm_cnt_ff == DLY_W'(1)) begin
                           mode_in = MODE_DRIVING;
                        end
                     end
                  end
                  MODE_ALCOHOL: begin
                     if (!ign_ff) begin
                        closed_in  = 1'b0;
                        arm_cnt_in = arm_delay_ff;
                        mode_in    = MODE_ARM_CNT;
                     end else begin
                        mode_in = closed_ff ? MODE_DRIVING : MODE_TRIPPED;
                     end
                  end
                  MODE_CLEAN: begin
                     closed_in = 1'b1;
                     if (!ign_ff) begin
                        off_cnt_in = clean_win_ff;
                        mode_in    = MODE_OFF_CNT;
                     end else begin
                        mode_in = MODE_DRIVING;
                     end
                  end
                  default: ;
               endcase
            end
            // reload while ignition is on, then count down
            if (ign_ff) begin
               rec_load = rec_hold_ff;
            end
            rec_cnt_in = (rec_load != '0) ? rec_load - 1'b1 : rec_load;
         end
         ACT_MINUTE: begin
            minutes_in = ign_ff ? minutes_ff + 1'b1 : '0;
         end
         ACT_BREATH: begin
            mode_in = alc_ff ? MODE_ALCOHOL : MODE_CLEAN;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_delay_ff  <= ARM_DELAY_RST;
         off_delay_ff  <= OFF_DELAY_RST;
         clean_win_ff  <= CLEAN_WIN_RST;
         rec_hold_ff   <= REC_HOLD_RST;
         first_rem_ff  <= FIRST_REM_RST;
         second_rem_ff <= SECOND_REM_RST;
         repeat_rem_ff <= REPEAT_REM_RST;
         debounce_ff   <= DEBOUNCE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ARM_DELAY:  arm_delay_ff  <= csr_wdata[DLY_W-1:0];
            REG_OFF_DELAY:  off_delay_ff  <= csr_wdata[DLY_W-1:0];
            REG_CLEAN_WIN:  clean_win_ff  <= csr_wdata[DLY_W-1:0];
            REG_REC_HOLD:   rec_hold_ff   <= csr_wdata[DLY_W-1:0];
            REG_FIRST_REM:  first_rem_ff  <= csr_wdata[MIN_W-1:0];
            REG_SECOND_REM: second_rem_ff <= csr_wdata[MIN_W-1:0];
            REG_REPEAT_REM: repeat_rem_ff <= csr_wdata[REP_W-1:0];
            REG_DEBOUNCE:   debounce_ff   <= csr_wdata[DEB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         ign_ff       <= 1'b0;
         mode_ff      <= MODE_DRIVING;
         closed_ff    <= 1'b0;
         off_cnt_ff   <= '0;
         arm_cnt_ff   <= '0;
         minutes_ff   <= '0;
         rec_cnt_ff   <= '0;
         pulse_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pulse_ff     <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            level_ff   <= level_in;
            ign_ff     <= ign_in;
            mode_ff    <= mode_in;
            closed_ff  <= closed_in;
            off_cnt_ff <= off_cnt_in;
            arm_cnt_ff <= arm_cnt_in;
            minutes_ff <= minutes_in;
            rec_cnt_ff <= rec_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_action;
         lvl_ff  <= req_ignition_level;
         alc_ff  <= req_alcohol_found;
         pair_ff <= req_pairing_busy;
         secs_ff <= req_seconds_now;
      end
      if (commit) begin
         out_relay_ff <= closed_in;
         out_ign_ff   <= ign_in;
         out_pulse_ff <= pulse_ff;
         out_rec_ff   <= (rec_cnt_in != '0);
         out_mode_ff  <= mode_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_relay_on     = out_relay_ff;
   assign rsp_ignition_on  = out_ign_ff;
   assign rsp_remind_pulse = out_pulse_ff;
   assign rsp_recording_on = out_rec_ff;
   assign rsp_mode         = out_mode_ff;

   a_div_from_calc: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIV)
      else $error("remainder pass started outside evaluation");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside commit");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> state_ff == ST_DIV)
      else $error("remainder finished while sequencer not waiting");

   a_pulse_second_only: assert property (@(posedge clock) disable iff (reset)
      commit && pulse_ff |-> act_ff == ACT_SECOND)
      else $error("reminder raised on a word other than a second tick");

endmodule

`default_nettype wire

// File: hdl/iirc_rem.sv
// ----------------------------------------------------------------------------
// iirc_rem - bit-serial remainder unit
// Restoring division of a drive-minute excess by the repeat interval, one
// dividend bit per cycle; reports whether the remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module iirc_rem (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [iirc_pkg::MIN_W-1:0]   dividend,
   input  wire logic [iirc_pkg::REP_W-1:0]   divisor,
   output iirc_pkg::rem_status_type          status
);
   import iirc_pkg::*;

   localparam int CNT_W = $clog2(MIN_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MIN_W-1:0]    quo_ff, quo_in;
   logic [REP_W-1:0]    rem_ff, rem_in;
   logic [REP_W-1:0]    div_ff, div_in;
   logic [REP_W:0]      trial;

   assign trial = {rem_ff, quo_ff[MIN_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MIN_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = REP_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[REP_W-1:0];
         end
         quo_in = {quo_ff[MIN_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("remainder unit did not go busy after start");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("remainder done without a finished pass");

endmodule

`default_nettype wire
